// ===== rtl/bba_pkg.sv =====
// Package of the buddy block allocator: default parameters, field widths,
// status codes and the word and tree-entry types. Depends on nothing.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int POOL_ORDER_DEF   = 16;
    localparam int MIN_ORDER_DEF    = 6;
    localparam int HEADER_BYTES_DEF = 8;

    localparam int REQ_BYTES_W = 17;
    localparam int NODE_IDX_W  = 11;
    localparam int OFFSET_W    = 16;
    localparam int ORDER_OUT_W = 5;
    localparam int BYTES_W     = 17;
    localparam int BLOCKS_W    = 11;
    localparam int ORDER_W     = 6;
    localparam int NEED_W      = 34;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD      = 2'd1;
    localparam logic [1:0] STATUS_NO_BLOCK = 2'd2;
    localparam logic [1:0] STATUS_FREE     = 2'd3;

    localparam logic ACTION_ALLOC = 1'b0;
    localparam logic ACTION_FREE  = 1'b1;

    typedef struct packed {
        logic                   action;
        logic [REQ_BYTES_W-1:0] request_bytes;
        logic [NODE_IDX_W-1:0]  node_index;
    } bba_req_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [NODE_IDX_W-1:0]  granted_node;
        logic [OFFSET_W-1:0]    block_offset;
        logic [ORDER_OUT_W-1:0] block_order;
        logic [BYTES_W-1:0]     bytes_in_use;
        logic [BYTES_W-1:0]     bytes_left;
        logic [BLOCKS_W-1:0]    blocks_in_use;
    } bba_res_t;

    typedef struct packed {
        logic               used;
        logic               split;
        logic [ORDER_W-1:0] order;
    } bba_entry_t;

    localparam int ENTRY_W = $bits(bba_entry_t);

endpackage

// ===== rtl/bba_if.sv =====
// Valid/ready channels of the buddy block allocator, one word per handshake.
// Depends on bba_pkg for the word types.
`timescale 1ns / 1ps

interface bba_req_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [bba_pkg::REQ_BYTES_W-1:0] request_bytes;
    logic [bba_pkg::NODE_IDX_W-1:0]  node_index;

    modport source (output valid, action, request_bytes, node_index, input ready);
    modport sink (input valid, action, request_bytes, node_index, output ready);
endinterface

interface bba_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      status;
    logic [bba_pkg::NODE_IDX_W-1:0]  granted_node;
    logic [bba_pkg::OFFSET_W-1:0]    block_offset;
    logic [bba_pkg::ORDER_OUT_W-1:0] block_order;
    logic [bba_pkg::BYTES_W-1:0]     bytes_in_use;
    logic [bba_pkg::BYTES_W-1:0]     bytes_left;
    logic [bba_pkg::BLOCKS_W-1:0]    blocks_in_use;

    modport source (output valid, status, granted_node, block_offset, block_order,
                    bytes_in_use, bytes_left, blocks_in_use, input ready);
    modport sink (input valid, status, granted_node, block_offset, block_order,
                  bytes_in_use, bytes_left, blocks_in_use, output ready);
endinterface

// ===== rtl/buddy_block_allocator.sv =====
// Top level of the buddy block allocator: tree memory, sequencer and the
// output register. Depends on bba_pkg, bba_if, bba_ram and bba_ctrl.
//
// The req channel takes one word per operation: action 0 allocates a block of
// request_bytes plus the header, rounded up to a power of two; action 1 frees
// the block at node_index. The rsp channel returns exactly one word per
// request, with status, the granted node, offset and order, and the byte and
// block totals after the operation. Requests are handled one at a time.
// An allocation rounds the size up one order at a time, searches the tree
// depth first, backing out of used or split nodes, then marks every ancestor
// of the found node as split and hands over the word. A free checks the node
// and walks up, merging with each free, unsplit sibling; a rejected request
// goes straight to the word. A search over a pool whose smallest blocks are
// all taken visits every node. After reset the tree memory is cleared, one
// node a cycle, all 2^(POOL_ORDER - MIN_ORDER + 1) - 1 nodes; req.ready
// stays low until then. A finished word waits in the output register while
// the receiver stalls; the next request is accepted meanwhile, and its word
// waits for the slot.
`timescale 1ns / 1ps

module buddy_block_allocator #(
    parameter int POOL_ORDER   = bba_pkg::POOL_ORDER_DEF,
    parameter int MIN_ORDER    = bba_pkg::MIN_ORDER_DEF,
    parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bba_req_if.sink    req,
    bba_rsp_if.source  rsp
);
    import bba_pkg::*;

    localparam int NODE_W = POOL_ORDER - MIN_ORDER + 1;

    bba_req_t          req_word;
    bba_res_t          res_word;
    bba_res_t          rsp_reg;
    logic              rsp_valid_reg;
    logic              res_valid;
    logic              res_ready;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    bba_entry_t        wr_data;
    logic [NODE_W-1:0] rd_addr;
    bba_entry_t        rd_data;

    assign req_word.action        = req.action;
    assign req_word.request_bytes = req.request_bytes;
    assign req_word.node_index    = req.node_index;

    assign res_ready = !rsp_valid_reg || rsp.ready;

    bba_ctrl #(
        .POOL_ORDER  (POOL_ORDER),
        .MIN_ORDER   (MIN_ORDER),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req.valid),
        .req_ready(req.ready),
        .req_word (req_word),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_word (res_word),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    bba_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH((1 << NODE_W) - 1)
    ) u_tree (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            rsp_reg <= res_word;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_reg.status;
    assign rsp.granted_node  = rsp_reg.granted_node;
    assign rsp.block_offset  = rsp_reg.block_offset;
    assign rsp.block_order   = rsp_reg.block_order;
    assign rsp.bytes_in_use  = rsp_reg.bytes_in_use;
    assign rsp.bytes_left    = rsp_reg.bytes_left;
    assign rsp.blocks_in_use = rsp_reg.blocks_in_use;

endmodule

// ===== rtl/bba_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/bba_ctrl.sv =====
// Sequencer of the buddy block allocator: size rounding, tree search, split
// marking, merge walk, counters and the clearing pass. Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_ctrl #(
    parameter int POOL_ORDER   = bba_pkg::POOL_ORDER_DEF,
    parameter int MIN_ORDER    = bba_pkg::MIN_ORDER_DEF,
    parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF,
    localparam int NODE_W      = POOL_ORDER - MIN_ORDER + 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  bba_pkg::bba_req_t       req_word,
    output logic                    res_valid,
    input  logic                    res_ready,
    output bba_pkg::bba_res_t       res_word,
    output logic                    wr_en,
    output logic [NODE_W-1:0]       wr_addr,
    output bba_pkg::bba_entry_t     wr_data,
    output logic [NODE_W-1:0]       rd_addr,
    input  bba_pkg::bba_entry_t     rd_data
);
    import bba_pkg::*;

    localparam longint NODE_COUNT = (64'd1 << NODE_W) - 64'd1;
    localparam int     UB_W       = POOL_ORDER + 1;

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SIZE  = 4'd2;
    localparam logic [3:0] ST_DWAIT = 4'd3;
    localparam logic [3:0] ST_DCHK  = 4'd4;
    localparam logic [3:0] ST_BACK  = 4'd5;
    localparam logic [3:0] ST_MARK  = 4'd6;
    localparam logic [3:0] ST_FWAIT = 4'd7;
    localparam logic [3:0] ST_FCHK  = 4'd8;
    localparam logic [3:0] ST_SWAIT = 4'd9;
    localparam logic [3:0] ST_FSIB  = 4'd10;
    localparam logic [3:0] ST_RES   = 4'd11;

    logic [3:0]         state_reg;
    logic [NODE_W-1:0]  clr_reg;
    logic [NODE_W-1:0]  node_reg;
    logic [NODE_W-1:0]  walk_reg;
    logic [NODE_W-1:0]  found_reg;
    logic [ORDER_W-1:0] cur_reg;
    logic [ORDER_W-1:0] want_reg;
    logic [ORDER_W-1:0] order_reg;
    logic [NEED_W-1:0]  need_reg;
    logic [1:0]         status_reg;
    logic               alloc_reg;
    logic [UB_W-1:0]    used_reg;
    logic [UB_W-1:0]    used_next;
    logic [NODE_W-1:0]  count_reg;
    logic [NODE_W-1:0]  count_next;

    logic [NEED_W-1:0]     need_in;
    logic                  bad_alloc;
    logic                  bad_free;
    logic [NODE_W-1:0]     node_parent;
    logic [NODE_W-1:0]     walk_parent;
    logic [NODE_W-1:0]     walk_sib;
    logic [NODE_W-1:0]     walk_psib;
    logic [NODE_W-1:0]     first_node;
    logic [POOL_ORDER-1:0] offset_full;
    logic [UB_W-1:0]       block_bytes;
    logic                  ok;

    assign need_in   = NEED_W'(req_word.request_bytes) + NEED_W'(HEADER_BYTES);
    assign bad_alloc = (req_word.request_bytes == '0)
                    || (need_in > (NEED_W'(1) << POOL_ORDER));
    assign bad_free  = 64'(req_word.node_index) >= NODE_COUNT;

    assign node_parent = (node_reg - NODE_W'(1)) >> 1;
    assign walk_parent = (walk_reg - NODE_W'(1)) >> 1;
    assign walk_sib    = walk_reg[0] ? walk_reg + NODE_W'(1) : walk_reg - NODE_W'(1);
    assign walk_psib   = walk_parent[0] ? walk_parent + NODE_W'(1)
                                        : walk_parent - NODE_W'(1);

    assign first_node  = NODE_W'((NODE_W+1)'(1) << (ORDER_W'(POOL_ORDER) - want_reg))
                       - NODE_W'(1);
    assign offset_full = POOL_ORDER'(found_reg - first_node) << want_reg;
    assign block_bytes = UB_W'(1) << order_reg;
    assign ok          = status_reg == STATUS_OK;

    always_comb
    begin
        used_next  = used_reg;
        count_next = count_reg;
        if (ok && alloc_reg)
        begin
            used_next  = used_reg + block_bytes;
            count_next = count_reg + NODE_W'(1);
        end
        else if (ok)
        begin
            used_next  = used_reg - block_bytes;
            count_next = count_reg - NODE_W'(1);
        end
    end

    assign req_ready = state_reg == ST_IDLE;
    assign res_valid = state_reg == ST_RES;
    assign rd_addr   = node_reg;

    always_comb
    begin
        res_word.status        = status_reg;
        res_word.granted_node  = (ok && alloc_reg) ? NODE_IDX_W'(found_reg) : '0;
        res_word.block_offset  = (ok && alloc_reg) ? OFFSET_W'(offset_full) : '0;
        res_word.block_order   = ok ? ORDER_OUT_W'(order_reg) : '0;
        res_word.bytes_in_use  = BYTES_W'(used_next);
        res_word.bytes_left    = BYTES_W'((UB_W'(1) << POOL_ORDER) - used_next);
        res_word.blocks_in_use = BLOCKS_W'(count_next);
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = node_reg;
        wr_data = '0;
        case (state_reg)
            ST_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
            end
            ST_DCHK:
            begin
                if (!rd_data.used && cur_reg == want_reg && !rd_data.split)
                begin
                    wr_en         = 1'b1;
                    wr_data.used  = 1'b1;
                    wr_data.order = want_reg;
                end
            end
            ST_MARK:
            begin
                if (node_reg != '0)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = node_parent;
                    wr_data.split = 1'b1;
                end
            end
            ST_FCHK:
            begin
                wr_en = rd_data.used;
            end
            ST_FSIB:
            begin
                if (!rd_data.used && !rd_data.split)
                begin
                    wr_en   = 1'b1;
                    wr_addr = walk_parent;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            clr_reg   <= '0;
            used_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_CLR:
                begin
                    clr_reg <= clr_reg + NODE_W'(1);
                    if (clr_reg == NODE_W'(NODE_COUNT - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        alloc_reg  <= req_word.action == ACTION_ALLOC;
                        status_reg <= STATUS_OK;
                        found_reg  <= '0;
                        order_reg  <= '0;
                        need_reg   <= need_in;
                        want_reg   <= ORDER_W'(MIN_ORDER);
                        node_reg   <= NODE_W'(req_word.node_index);
                        walk_reg   <= NODE_W'(req_word.node_index);
                        if (req_word.action == ACTION_ALLOC)
                        begin
                            if (bad_alloc)
                            begin
                                status_reg <= STATUS_BAD;
                                state_reg  <= ST_RES;
                            end
                            else
                            begin
                                state_reg <= ST_SIZE;
                            end
                        end
                        else if (bad_free)
                        begin
                            status_reg <= STATUS_BAD;
                            state_reg  <= ST_RES;
                        end
                        else
                        begin
                            state_reg <= ST_FWAIT;
                        end
                    end
                end
                ST_SIZE:
                begin
                    if (need_reg > (NEED_W'(1) << want_reg))
                    begin
                        want_reg <= want_reg + ORDER_W'(1);
                    end
                    else
                    begin
                        node_reg  <= '0;
                        cur_reg   <= ORDER_W'(POOL_ORDER);
                        state_reg <= ST_DWAIT;
                    end
                end
                ST_DWAIT:
                begin
                    state_reg <= ST_DCHK;
                end
                ST_DCHK:
                begin
                    if (rd_data.used)
                    begin
                        state_reg <= ST_BACK;
                    end
                    else if (cur_reg == want_reg)
                    begin
                        if (rd_data.split)
                        begin
                            state_reg <= ST_BACK;
                        end
                        else
                        begin
                            found_reg <= node_reg;
                            order_reg <= want_reg;
                            state_reg <= ST_MARK;
                        end
                    end
                    else
                    begin
                        node_reg  <= {node_reg[NODE_W-2:0], 1'b1};
                        cur_reg   <= cur_reg - ORDER_W'(1);
                        state_reg <= ST_DWAIT;
                    end
                end
                ST_BACK:
                begin
                    if (node_reg == '0)
                    begin
                        status_reg <= STATUS_NO_BLOCK;
                        state_reg  <= ST_RES;
                    end
                    else if (node_reg[0])
                    begin
                        node_reg  <= node_reg + NODE_W'(1);
                        state_reg <= ST_DWAIT;
                    end
                    else
                    begin
                        node_reg <= node_parent;
                        cur_reg  <= cur_reg + ORDER_W'(1);
                    end
                end
                ST_MARK:
                begin
                    if (node_reg == '0)
                    begin
                        state_reg <= ST_RES;
                    end
                    else
                    begin
                        node_reg <= node_parent;
                    end
                end
                ST_FWAIT:
                begin
                    state_reg <= ST_FCHK;
                end
                ST_FCHK:
                begin
                    if (!rd_data.used)
                    begin
                        status_reg <= STATUS_FREE;
                        state_reg  <= ST_RES;
                    end
                    else
                    begin
                        order_reg <= rd_data.order;
                        if (walk_reg == '0)
                        begin
                            state_reg <= ST_RES;
                        end
                        else
                        begin
                            node_reg  <= walk_sib;
                            state_reg <= ST_SWAIT;
                        end
                    end
                end
                ST_SWAIT:
                begin
                    state_reg <= ST_FSIB;
                end
                ST_FSIB:
                begin
                    if (rd_data.used || rd_data.split || walk_parent == '0)
                    begin
                        state_reg <= ST_RES;
                    end
                    else
                    begin
                        walk_reg  <= walk_parent;
                        node_reg  <= walk_psib;
                        state_reg <= ST_SWAIT;
                    end
                end
                ST_RES:
                begin
                    if (res_ready)
                    begin
                        used_reg  <= used_next;
                        count_reg <= count_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/bba_checker.sv =====
// Port-level checks of the buddy block allocator and the bind that attaches
// them to the top level. Depends on bba_pkg and buddy_block_allocator.
`timescale 1ns / 1ps

module bba_checker #(
    parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF,
    parameter int MIN_ORDER  = bba_pkg::MIN_ORDER_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [1:0]                      status,
    input logic [bba_pkg::NODE_IDX_W-1:0]  granted_node,
    input logic [bba_pkg::OFFSET_W-1:0]    block_offset,
    input logic [bba_pkg::ORDER_OUT_W-1:0] block_order,
    input logic [bba_pkg::BYTES_W-1:0]     bytes_in_use,
    input logic [bba_pkg::BYTES_W-1:0]     bytes_left
);
    import bba_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("Response word dropped while stalled.");

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != STATUS_OK |->
            granted_node == '0 && block_offset == '0 && block_order == '0)
        else $error("Failed operation reports block fields.");

    a_bytes_sum: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> BYTES_W'(bytes_in_use + bytes_left)
                      == BYTES_W'(64'd1 << POOL_ORDER))
        else $error("Allocated and free byte totals disagree with the pool size.");

    a_order_min: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STATUS_OK && block_order != '0 |->
            32'(block_order) >= MIN_ORDER)
        else $error("Block order below the minimum.");

    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STATUS_OK |->
            (32'(block_offset) & ((32'd1 << MIN_ORDER) - 32'd1)) == 32'd0)
        else $error("Granted block is not aligned to the minimum block size.");

endmodule

bind buddy_block_allocator bba_checker #(
    .POOL_ORDER(POOL_ORDER),
    .MIN_ORDER (MIN_ORDER)
) u_bba_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .granted_node(rsp.granted_node),
    .block_offset(rsp.block_offset),
    .block_order (rsp.block_order),
    .bytes_in_use(rsp.bytes_in_use),
    .bytes_left  (rsp.bytes_left)
);

// ===== test/tb.sv =====
// Self-checking testbench of the buddy block allocator: directed table, then random
// allocate/free traffic checked against a tree model kept in the bench.
// Depends on bba_pkg, the bba_if interfaces and the buddy_block_allocator RTL.
`timescale 1ns / 1ps

module tb;
    import bba_pkg::*;

    localparam int NODES     = 2047;
    localparam int POOL      = 65536;
    localparam int MAX_GAP   = 17;
    localparam int LONG_HOLD = 400;
    localparam int WD_LIMIT  = 50000;

    typedef struct {
        logic     act;
        int       rq;
        int       nd;
        bit       typed;
        bba_res_t r;
    } row_t;

    logic clk;
    logic rst_n;

    bba_req_if req();
    bba_rsp_if rsp();

    buddy_block_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    bit       tree_used [NODES];
    bit       tree_split[NODES];
    int       tree_order[NODES];
    int       used_bytes_m;
    int       used_blocks_m;
    int       live_nodes[$];
    bba_res_t pending_words[$];
    int       errors;
    int       idle_cycles;
    bit       hold_long;
    int       n_alloc_ok;
    int       n_free_ok;
    int       n_rejects;
    int       max_blocks;
    row_t     rows[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int claim_block(int n, int cur, int want);
        int got;
        if (n >= NODES || tree_used[n])
            return -1;
        if (cur == want)
        begin
            if (tree_split[n])
                return -1;
            tree_used[n]  = 1'b1;
            tree_order[n] = want;
            return n;
        end
        if (cur < want)
            return -1;
        got = claim_block(2 * n + 1, cur - 1, want);
        if (got < 0)
            got = claim_block(2 * n + 2, cur - 1, want);
        if (got >= 0)
            tree_split[n] = 1'b1;
        return got;
    endfunction

    function automatic bba_res_t apply_request(logic act, int rq, int nd);
        bba_res_t w;
        int       o;
        int       idx;
        int       n;
        int       sib;
        int       par;
        w = '0;
        if (act == ACTION_ALLOC)
        begin
            if (rq == 0 || rq + HEADER_BYTES_DEF > POOL)
                w.status = STATUS_BAD;
            else
            begin
                o = 0;
                while ((1 << o) < rq + HEADER_BYTES_DEF)
                    o++;
                if (o < MIN_ORDER_DEF)
                    o = MIN_ORDER_DEF;
                idx = claim_block(0, POOL_ORDER_DEF, o);
                if (idx < 0)
                    w.status = STATUS_NO_BLOCK;
                else
                begin
                    w.status       = STATUS_OK;
                    w.granted_node = NODE_IDX_W'(idx);
                    w.block_offset = OFFSET_W'((idx - ((1 << (POOL_ORDER_DEF - o)) - 1)) << o);
                    w.block_order  = ORDER_OUT_W'(o);
                    used_bytes_m  += 1 << o;
                    used_blocks_m++;
                    live_nodes.push_back(idx);
                end
            end
        end
        else if (nd >= NODES)
            w.status = STATUS_BAD;
        else if (!tree_used[nd])
            w.status = STATUS_FREE;
        else
        begin
            w.status      = STATUS_OK;
            w.block_order = ORDER_OUT_W'(tree_order[nd]);
            tree_used[nd] = 1'b0;
            n = nd;
            while (n != 0)
            begin
                sib = (n & 1) ? n + 1 : n - 1;
                par = (n - 1) >> 1;
                if (tree_used[sib] || tree_split[sib])
                    break;
                tree_split[par] = 1'b0;
                tree_used[par]  = 1'b0;
                n = par;
            end
            used_bytes_m -= 1 << tree_order[nd];
            used_blocks_m--;
            foreach (live_nodes[i])
                if (live_nodes[i] == nd)
                begin
                    live_nodes.delete(i);
                    break;
                end
        end
        w.bytes_in_use  = BYTES_W'(used_bytes_m);
        w.bytes_left    = BYTES_W'(POOL - used_bytes_m);
        w.blocks_in_use = BLOCKS_W'(used_blocks_m);
        return w;
    endfunction

    function automatic row_t mk(logic act, int rq, int nd, bit typed, logic [1:0] st,
                                int gn, int off, int ord, int ab, int fb, int nb);
        row_t r;
        r.act   = act;
        r.rq    = rq;
        r.nd    = nd;
        r.typed = typed;
        r.r     = '{st, NODE_IDX_W'(gn), OFFSET_W'(off), ORDER_OUT_W'(ord),
                    BYTES_W'(ab), BYTES_W'(fb), BLOCKS_W'(nb)};
        return r;
    endfunction

    task automatic report(string field, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        errors++;
    endtask

    task automatic send(logic act, int rq, int nd, bit typed, bba_res_t typed_word);
        int       gap;
        bba_res_t w;
        w = apply_request(act, rq, nd);
        if (w.status == STATUS_OK && act == ACTION_ALLOC)
            n_alloc_ok++;
        else if (w.status == STATUS_OK)
            n_free_ok++;
        else
            n_rejects++;
        if (used_blocks_m > max_blocks)
            max_blocks = used_blocks_m;
        pending_words.push_back(typed ? typed_word : w);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.action        <= act;
        req.request_bytes <= REQ_BYTES_W'(rq);
        req.node_index    <= NODE_IDX_W'(nd);
        do @(posedge clk); while (!req.ready);
    endtask

    task automatic send_row(row_t r);
        send(r.act, r.rq, r.nd, r.typed, r.r);
    endtask

    task automatic random_item(int free_bias);
        int       r;
        int       sz;
        bba_res_t none;
        none = '0;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            if ($urandom_range(0, 1))
                send(ACTION_ALLOC, $urandom_range(0, 131071), $urandom_range(0, 2047), 0, none);
            else
                send(ACTION_FREE, $urandom_range(0, 131071), $urandom_range(0, 2047), 0, none);
        end
        else if (r < 12 + free_bias && live_nodes.size() > 0)
            send(ACTION_FREE, $urandom_range(0, 131071),
                 live_nodes[$urandom_range(0, live_nodes.size() - 1)], 0, none);
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                sz = $urandom_range(1, 200);
            else if (r < 95)
                sz = $urandom_range(1, 4096);
            else
                sz = $urandom_range(1, 65536);
            send(ACTION_ALLOC, sz, $urandom_range(0, 2047), 0, none);
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        req.valid         <= 1'b0;
        req.action        <= ACTION_ALLOC;
        req.request_bytes <= '0;
        req.node_index    <= '0;
        errors        = 0;
        used_bytes_m  = 0;
        used_blocks_m = 0;
        hold_long     = 1'b0;
        foreach (tree_used[i])
        begin
            tree_used[i]  = 1'b0;
            tree_split[i] = 1'b0;
            tree_order[i] = 0;
        end
        rows.push_back(mk(ACTION_FREE, 0, 0, 1, STATUS_FREE, 0, 0, 0, 0, POOL, 0));
        rows.push_back(mk(ACTION_ALLOC, 0, 0, 1, STATUS_BAD, 0, 0, 0, 0, POOL, 0));
        rows.push_back(mk(ACTION_ALLOC, 65529, 0, 1, STATUS_BAD, 0, 0, 0, 0, POOL, 0));
        rows.push_back(mk(ACTION_ALLOC, 65536, 0, 1, STATUS_BAD, 0, 0, 0, 0, POOL, 0));
        rows.push_back(mk(ACTION_ALLOC, 131071, 2047, 1, STATUS_BAD, 0, 0, 0, 0, POOL, 0));
        rows.push_back(mk(ACTION_ALLOC, 65528, 0, 1, STATUS_OK, 0, 0, 16, POOL, 0, 1));
        rows.push_back(mk(ACTION_ALLOC, 1, 0, 1, STATUS_NO_BLOCK, 0, 0, 0, POOL, 0, 1));
        rows.push_back(mk(ACTION_FREE, 0, 2047, 1, STATUS_BAD, 0, 0, 0, POOL, 0, 1));
        rows.push_back(mk(ACTION_FREE, 0, 1, 1, STATUS_FREE, 0, 0, 0, POOL, 0, 1));
        rows.push_back(mk(ACTION_FREE, 131071, 0, 1, STATUS_OK, 0, 0, 16, 0, POOL, 0));
        rows.push_back(mk(ACTION_ALLOC, 56, 0, 1, STATUS_OK, 1023, 0, 6, 64, POOL - 64, 1));
        rows.push_back(mk(ACTION_ALLOC, 57, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(ACTION_ALLOC, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(ACTION_FREE, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(ACTION_FREE, 0, 1023, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(ACTION_ALLOC, 32760, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(ACTION_ALLOC, 32760, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(ACTION_FREE, 0, 2046, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(ACTION_FREE, 0, 2, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(ACTION_FREE, 0, 1024, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(ACTION_ALLOC, 65528, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        foreach (rows[i])
            send_row(rows[i]);
        for (int k = 0; k < 1150; k++)
        begin
            if (k == 300)
                hold_long = 1'b1;
            if (k == 700)
            begin
                req.valid <= 1'b0;
                wait (pending_words.size() == 0);
                @(posedge clk);
            end
            if (k % 350 == 349)
                while (live_nodes.size() > 0)
                    random_item(88);
            else if (k < 200 || (k / 100) % 2 == 0)
                random_item(25);
            else
                random_item(50);
        end
        while (live_nodes.size() > 0)
            random_item(88);
        req.valid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (200) @(posedge clk);
        $display("covered %0d good allocations, %0d good frees, %0d rejected requests",
                 n_alloc_ok, n_free_ok, n_rejects);
        $display("peak of %0d blocks held at once, pool drained back to empty", max_blocks);
        if (errors == 0)
            $display("buddy_block_allocator test passed");
        else
            $display("buddy_block_allocator test failed");
        $finish;
    end

    initial
    begin
        int       gap;
        bba_res_t w;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                hold_long = 1'b0;
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!rsp.valid);
            if (pending_words.size() == 0)
            begin
                report("unexpected word", 1, 0);
            end
            else
            begin
                w = pending_words.pop_front();
                if (rsp.status !== w.status)
                    report("status", rsp.status, w.status);
                if (rsp.granted_node !== w.granted_node)
                    report("granted_node", rsp.granted_node, w.granted_node);
                if (rsp.block_offset !== w.block_offset)
                    report("block_offset", rsp.block_offset, w.block_offset);
                if (rsp.block_order !== w.block_order)
                    report("block_order", rsp.block_order, w.block_order);
                if (rsp.bytes_in_use !== w.bytes_in_use)
                    report("bytes_in_use", rsp.bytes_in_use, w.bytes_in_use);
                if (rsp.bytes_left !== w.bytes_left)
                    report("bytes_left", rsp.bytes_left, w.bytes_left);
                if (rsp.blocks_in_use !== w.blocks_in_use)
                    report("blocks_in_use", rsp.blocks_in_use, w.blocks_in_use);
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("timeout with %0d words outstanding", pending_words.size());
                $display("buddy_block_allocator test failed");
                $finish;
            end
        end
    end

endmodule
